// ----- rtl/hid_boot_keyboard_report_builder_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the HID boot keyboard report builder
// Shared shorthand for clocked, reset-qualified property checks.
// ----------------------------------------------------------------------------
`ifndef HID_BOOT_KEYBOARD_REPORT_BUILDER_MACROS_SVH
`define HID_BOOT_KEYBOARD_REPORT_BUILDER_MACROS_SVH

// Check that cond holds on the same edge as trig.
`define HBK_ASSERT_SAME(label, clk, rst_n, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// Check that cond holds on the edge after trig.
`define HBK_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ----- rtl/hbk_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbk_pkg
// Types, usage codes and the Colemak remap for the boot keyboard report builder.
// ----------------------------------------------------------------------------
package hbk_pkg;

  typedef logic [7:0] usage_t;

  // Number of key slots in a boot report
  localparam int unsigned REPORT_FIELD_SLOTS   = 6;
  localparam int unsigned REPORT_SLOTS_DEFAULT = 6;

  // Configuration port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic        REG_COLEMAK_LAYOUT = 1'b0;

  // Usage codes
  localparam usage_t USAGE_NONE      = 8'h00;
  localparam usage_t USAGE_ROLLOVER  = 8'h01;
  localparam usage_t USAGE_MUTE      = 8'h7F;
  localparam usage_t USAGE_MOD_FIRST = 8'hE0;
  localparam usage_t USAGE_MOD_LAST  = 8'hE7;
  localparam usage_t USAGE_LAYER     = 8'hFE;
  localparam usage_t USAGE_FN        = 8'hFF;

  typedef struct packed {
    usage_t physical_usage;
    logic   key_is_host;
    logic   last_key;
  } key_item_t;

  typedef struct packed {
    logic [7:0]                         modifier_byte;
    usage_t [REPORT_FIELD_SLOTS-1:0]    slots;
  } report_t;

  // Fixed Colemak translation of letter and semicolon usages
  function automatic usage_t colemak_map(input usage_t u);
    usage_t r;
    case (u)
      8'h08:   r = 8'h09;
      8'h15:   r = 8'h13;
      8'h17:   r = 8'h0A;
      8'h1C:   r = 8'h0D;
      8'h18:   r = 8'h0F;
      8'h0C:   r = 8'h18;
      8'h12:   r = 8'h1C;
      8'h13:   r = 8'h33;
      8'h16:   r = 8'h15;
      8'h07:   r = 8'h16;
      8'h09:   r = 8'h17;
      8'h0A:   r = 8'h07;
      8'h0D:   r = 8'h11;
      8'h0E:   r = 8'h08;
      8'h0F:   r = 8'h0C;
      8'h33:   r = 8'h12;
      8'h11:   r = 8'h0E;
      default: r = u;
    endcase
    return r;
  endfunction

  // Usages handled on the keyboard and never sent to the host
  function automatic logic is_local(input usage_t u);
    return (u == USAGE_NONE) || (u == USAGE_FN) || (u == USAGE_LAYER) || (u == USAGE_MUTE);
  endfunction

endpackage

// ----- rtl/hbk_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbk key and report channels
// Valid/ready channels for key items in and boot reports out.
// ----------------------------------------------------------------------------
interface hbk_key_if;
  logic       valid;
  logic       ready;
  logic [7:0] physical_usage;
  logic       key_is_host;
  logic       last_key;

  modport source (output valid, physical_usage, key_is_host, last_key, input ready);
  modport sink   (input valid, physical_usage, key_is_host, last_key, output ready);
endinterface

interface hbk_report_if;
  logic       valid;
  logic       ready;
  logic [7:0] modifier_byte;
  logic [7:0] slot_0;
  logic [7:0] slot_1;
  logic [7:0] slot_2;
  logic [7:0] slot_3;
  logic [7:0] slot_4;
  logic [7:0] slot_5;

  modport source (output valid, modifier_byte, slot_0, slot_1, slot_2, slot_3, slot_4,
                  slot_5, input ready);
  modport sink   (input valid, modifier_byte, slot_0, slot_1, slot_2, slot_3, slot_4,
                  slot_5, output ready);
endinterface

// ----- rtl/hid_boot_keyboard_report_builder.sv -----
// ----------------------------------------------------------------------------
// hid_boot_keyboard_report_builder
// Collects key positions of one scan into a 6KRO boot keyboard report.
// Throughput: one key item per cycle unless a last-key item waits for a held
//   report; the store update for one item is a single pass over the parallel
//   duplicate compares of all slots. A report leaves after its last-key item
//   is accepted, through the input register, then the report register.
// Reset: store, layout register and both valid flags clear asynchronously.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hid_boot_keyboard_report_builder_macros.svh"

module hid_boot_keyboard_report_builder #(
  parameter int unsigned REPORT_SLOTS = hbk_pkg::REPORT_SLOTS_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration port
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [hbk_pkg::PADDR_W-1:0]  paddr_i,
  input  logic [hbk_pkg::PDATA_W-1:0]  pwdata_i,
  output logic [hbk_pkg::PDATA_W-1:0]  prdata_o,
  output logic                         pready_o,
  // channels
  hbk_key_if.sink                      key_i,
  hbk_report_if.source                 report_o
);
  import hbk_pkg::*;

  localparam int unsigned CNT_W = $clog2(REPORT_SLOTS + 1);

  // Configuration register
  logic colemak_q;
  logic cfg_sel;

  assign pready_o = 1'b1;
  assign cfg_sel  = (paddr_i[2] == REG_COLEMAK_LAYOUT);
  assign prdata_o = cfg_sel ? {{(PDATA_W-1){1'b0}}, colemak_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colemak_q <= 1'b0;
    end else if (psel_i && penable_i && pwrite_i && pready_o && cfg_sel) begin
      colemak_q <= pwdata_i[0];
    end
  end

  // Input register
  key_item_t s1_q;
  logic      s1_valid_q;
  logic      s1_adv;
  logic      rpt_valid_q;

  assign s1_adv      = s1_valid_q && (!s1_q.last_key || !rpt_valid_q || report_o.ready);
  assign key_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (key_i.ready) begin
      s1_valid_q <= key_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_i.valid && key_i.ready) begin
      s1_q.physical_usage <= key_i.physical_usage;
      s1_q.key_is_host    <= key_i.key_is_host;
      s1_q.last_key       <= key_i.last_key;
    end
  end

  // Store of the pending report
  logic [7:0]             mods_q, mods_d, mods_upd;
  usage_t                 slot_q   [REPORT_SLOTS];
  usage_t                 slot_d   [REPORT_SLOTS];
  usage_t                 slot_upd [REPORT_SLOTS];
  logic [CNT_W-1:0]       filled_q, filled_d, filled_upd;
  usage_t                 usage;
  logic                   is_mod;
  logic                   hit;
  logic                   take;
  report_t                rpt_q, rpt_d;

  assign usage  = colemak_q ? colemak_map(s1_q.physical_usage) : s1_q.physical_usage;
  assign is_mod = (usage >= USAGE_MOD_FIRST) && (usage <= USAGE_MOD_LAST);
  assign take   = s1_adv && s1_q.key_is_host && !is_local(usage);

  // Compare against every slot in parallel
  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < REPORT_SLOTS; i++) begin
      hit = hit | (slot_q[i] == usage);
    end
  end

  // Apply the item, then capture and clear on the last key
  always_comb begin
    mods_upd   = mods_q;
    filled_upd = filled_q;
    for (int i = 0; i < REPORT_SLOTS; i++) begin
      slot_upd[i] = slot_q[i];
    end
    if (take) begin
      if (is_mod) begin
        mods_upd = mods_q | (8'd1 << usage[2:0]);
      end else if (!hit) begin
        if (filled_q < CNT_W'(REPORT_SLOTS)) begin
          for (int i = 0; i < REPORT_SLOTS; i++) begin
            if (filled_q == CNT_W'(i)) begin
              slot_upd[i] = usage;
            end
          end
          filled_upd = filled_q + CNT_W'(1);
        end else begin
          for (int i = 0; i < REPORT_SLOTS; i++) begin
            slot_upd[i] = USAGE_ROLLOVER;
          end
        end
      end
    end

    rpt_d = rpt_q;
    rpt_d.modifier_byte = mods_upd;
    for (int j = 0; j < REPORT_FIELD_SLOTS; j++) begin
      rpt_d.slots[j] = USAGE_NONE;
      if (j < REPORT_SLOTS) begin
        rpt_d.slots[j] = slot_upd[j];
      end
    end

    if (s1_adv && s1_q.last_key) begin
      mods_d   = '0;
      filled_d = '0;
      for (int i = 0; i < REPORT_SLOTS; i++) begin
        slot_d[i] = USAGE_NONE;
      end
    end else begin
      mods_d   = mods_upd;
      filled_d = filled_upd;
      for (int i = 0; i < REPORT_SLOTS; i++) begin
        slot_d[i] = slot_upd[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mods_q   <= '0;
      filled_q <= '0;
      for (int i = 0; i < REPORT_SLOTS; i++) begin
        slot_q[i] <= USAGE_NONE;
      end
    end else begin
      mods_q   <= mods_d;
      filled_q <= filled_d;
      for (int i = 0; i < REPORT_SLOTS; i++) begin
        slot_q[i] <= slot_d[i];
      end
    end
  end

  // Report register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rpt_valid_q <= 1'b0;
    end else begin
      rpt_valid_q <= (s1_adv && s1_q.last_key) || (rpt_valid_q && !report_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_q.last_key) begin
      rpt_q <= rpt_d;
    end
  end

  assign report_o.valid         = rpt_valid_q;
  assign report_o.modifier_byte = rpt_q.modifier_byte;
  assign report_o.slot_0        = rpt_q.slots[0];
  assign report_o.slot_1        = rpt_q.slots[1];
  assign report_o.slot_2        = rpt_q.slots[2];
  assign report_o.slot_3        = rpt_q.slots[3];
  assign report_o.slot_4        = rpt_q.slots[4];
  assign report_o.slot_5        = rpt_q.slots[5];

  // Checks
  `HBK_ASSERT_SAME(a_fill_bound, clk_i, rst_ni, 1'b1, filled_q <= CNT_W'(REPORT_SLOTS),
                   "slot fill count beyond slot count")
  `HBK_ASSERT_NEXT(a_clear_after_last, clk_i, rst_ni, s1_adv && s1_q.last_key,
                   filled_q == '0 && mods_q == '0 && rpt_valid_q,
                   "store not cleared or report not posted after last key")
  `HBK_ASSERT_SAME(a_ready_when_empty, clk_i, rst_ni, !s1_valid_q, key_i.ready,
                   "input stalled with empty input register")
  `HBK_ASSERT_NEXT(a_hold_on_idle, clk_i, rst_ni, !s1_valid_q, $stable(filled_q),
                   "store changed with no item in flight")

endmodule
